>>> design/bzf_pkg.sv
// ----------------------------------------------------------------------------
// bzf_pkg
// Shared types and constants for the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package bzf_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SEG_W         = 6;
    localparam int MIN_SEG       = 9;
    localparam int MAX_SEG_RST   = 63;
    localparam int AREA_W        = 64;
    localparam int SQRT_STEPS    = AREA_W / 2;
    localparam int CF_W          = 36;
    localparam int VAL_W         = 48;
    localparam int QUO_W         = 52;
    localparam int DEN_W         = 3 * SEG_W;
    localparam int N_DIFF        = 6;
    localparam int N_LANE        = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } bzf_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last;
    } bzf_out_t;

    // value = q * d + r, 0 <= r < d
    typedef struct packed {
        logic signed [QUO_W-1:0] q;
        logic [DEN_W-1:0]        r;
    } bzf_mix_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_AREA,
        ST_SQRT,
        ST_CLAMP,
        ST_COEF,
        ST_MULS,
        ST_DIFF,
        ST_DIV,
        ST_INIT,
        ST_UPD,
        ST_EMIT,
        ST_LAST
    } bzf_state_t;

endpackage

>>> design/bzf_div.sv
// ----------------------------------------------------------------------------
// bzf_div
// Radix-2 restoring divider, signed dividend by unsigned divisor, one
// quotient bit per cycle. Result is floor quotient and nonnegative remainder.
// ----------------------------------------------------------------------------
module bzf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [bzf_pkg::VAL_W-1:0]    dividend,
    input  logic [bzf_pkg::DEN_W-1:0]           divisor,
    output logic                                done,
    output bzf_pkg::bzf_mix_t                   quot
);
    import bzf_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [VAL_W-1:0] mq_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic             rem_nz;
    logic [QUO_W-1:0] q_mag;

    assign trial  = {rem_reg, mq_reg[VAL_W-1]};
    assign ge     = trial >= {1'b0, den_reg};
    assign rem_nz = |rem_reg;
    assign q_mag  = QUO_W'(mq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(VAL_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= dividend[VAL_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
            mq_reg  <= dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            mq_reg  <= {mq_reg[VAL_W-2:0], ge};
        end
    end

    always_comb
    begin
        if (neg_reg && rem_nz)
        begin
            quot.q = -$signed(q_mag) - QUO_W'(1);
            quot.r = den_reg - rem_reg;
        end
        else if (neg_reg)
        begin
            quot.q = -$signed(q_mag);
            quot.r = rem_reg;
        end
        else
        begin
            quot.q = $signed(q_mag);
            quot.r = rem_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> design/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Flattens a cubic Bezier curve into a polyline by forward differencing.
// ----------------------------------------------------------------------------
//  channel   | handshake          | word
//  ----------+--------------------+-----------------------------------
//  input     | start / busy       | points  (bzf_in_t, four ctrl points)
//  result    | valid (1 cycle)    | result  (bzf_out_t, point + last)
//  config    | cfg_we             | cfg_data (max_segments)
//
//  Start point leaves the cycle after accept. Area, shared multiplier
//  and a 32-step square root set the short path. Long path adds six
//  divisions, then an update and an emit state per interior point.
//  Results cannot be stalled. Reset is asynchronous, active low;
//  max_segments resets to 63.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener #(
    parameter int COORD_FRAC_BITS = bzf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bzf_pkg::bzf_in_t              points,
    input  logic                          cfg_we,
    input  logic [bzf_pkg::SEG_W-1:0]     cfg_data,
    output logic                          valid,
    output bzf_pkg::bzf_out_t             result
);
    import bzf_pkg::*;

    bzf_state_t state_reg, state_next;

    logic [SEG_W-1:0]      max_seg_reg;
    bzf_in_t               pts_reg;
    logic [1:0]            k_reg;
    logic [AREA_W-1:0]     prod_reg [4];
    logic                  neg_reg  [4];
    logic [AREA_W-1:0]     sq_rem_reg;
    logic [AREA_W-1:0]     sq_root_reg;
    logic [4:0]            sq_pos_reg;
    logic [SEG_W-1:0]      n_reg;
    logic [2*SEG_W-1:0]    n2_reg;
    logic [DEN_W-1:0]      d_reg;
    logic signed [CF_W-1:0]  ca_reg [N_LANE];
    logic signed [CF_W-1:0]  cb_reg [N_LANE];
    logic signed [CF_W-1:0]  cc_reg [N_LANE];
    logic signed [VAL_W-1:0] bn_reg [N_LANE];
    logic signed [VAL_W-1:0] cn_reg [N_LANE];
    logic signed [VAL_W-1:0] val_reg [N_DIFF];
    bzf_mix_t              dm_reg  [N_DIFF];
    bzf_mix_t              acc_reg [N_LANE];
    logic [2:0]            dv_idx_reg;
    logic                  dv_pend_reg;
    logic [SEG_W-1:0]      i_reg;
    logic                  valid_reg;
    bzf_out_t              result_reg;

    logic signed [COORD_W-1:0] p0 [N_LANE];
    logic signed [COORD_W-1:0] p1 [N_LANE];
    logic signed [COORD_W-1:0] p2 [N_LANE];
    logic signed [COORD_W-1:0] p3 [N_LANE];

    logic [COORD_W:0]      dif_a, dif_b;
    logic [COORD_W-1:0]    mag_a, mag_b;
    logic [AREA_W-1:0]     area1, area2;
    logic [AREA_W-1:0]     sq_bit, sq_try;
    logic [AREA_W-1:0]     n_raw;
    logic [SEG_W-1:0]      cap, n_clamp;
    logic                  few_seg;
    logic                  accept, emit_pt, emit_end;
    logic                  div_go, div_done;
    bzf_mix_t              div_quot;

    function automatic logic [AREA_W-1:0] abs_cross(
        input logic [AREA_W-1:0] m1,
        input logic [AREA_W-1:0] m2,
        input logic              n1,
        input logic              n2
    );
        logic [AREA_W:0] t;
        t = {1'b0, m1} + {1'b0, m2};
        if (n1 != n2)
            return t[AREA_W] ? '1 : t[AREA_W-1:0];
        return (m1 >= m2) ? m1 - m2 : m2 - m1;
    endfunction

    function automatic logic signed [CF_W-1:0] ext(input logic signed [COORD_W-1:0] p);
        logic signed [CF_W-1:0] e;
        e = CF_W'(p);
        return e;
    endfunction

    function automatic bzf_mix_t madd(
        input bzf_mix_t         a,
        input bzf_mix_t         b,
        input logic [DEN_W-1:0] d
    );
        bzf_mix_t       s;
        logic [DEN_W:0] rs;
        rs = {1'b0, a.r} + {1'b0, b.r};
        if (rs >= {1'b0, d})
        begin
            s.r = DEN_W'(rs - {1'b0, d});
            s.q = a.q + b.q + QUO_W'(1);
        end
        else
        begin
            s.r = rs[DEN_W-1:0];
            s.q = a.q + b.q;
        end
        return s;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] base,
        input logic signed [QUO_W-1:0]   q
    );
        logic signed [QUO_W:0] s;
        s = (QUO_W+1)'(base) + (QUO_W+1)'(q);
        if ((&s[QUO_W:COORD_W-1]) || !(|s[QUO_W:COORD_W-1]))
            return s[COORD_W-1:0];
        return s[QUO_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    always_comb
    begin
        p0[0] = pts_reg.start_x;  p0[1] = pts_reg.start_y;
        p1[0] = pts_reg.ctrl1_x;  p1[1] = pts_reg.ctrl1_y;
        p2[0] = pts_reg.ctrl2_x;  p2[1] = pts_reg.ctrl2_y;
        p3[0] = pts_reg.end_x;    p3[1] = pts_reg.end_y;
    end

    // cross product operand select
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                dif_a = {pts_reg.start_x[31], pts_reg.start_x} - {pts_reg.ctrl2_x[31], pts_reg.ctrl2_x};
                dif_b = {pts_reg.end_y[31], pts_reg.end_y} - {pts_reg.ctrl1_y[31], pts_reg.ctrl1_y};
            end
            2'd1:
            begin
                dif_a = {pts_reg.start_y[31], pts_reg.start_y} - {pts_reg.ctrl2_y[31], pts_reg.ctrl2_y};
                dif_b = {pts_reg.end_x[31], pts_reg.end_x} - {pts_reg.ctrl1_x[31], pts_reg.ctrl1_x};
            end
            2'd2:
            begin
                dif_a = {pts_reg.start_x[31], pts_reg.start_x} - {pts_reg.end_x[31], pts_reg.end_x};
                dif_b = {pts_reg.ctrl2_y[31], pts_reg.ctrl2_y} - {pts_reg.ctrl1_y[31], pts_reg.ctrl1_y};
            end
            default:
            begin
                dif_a = {pts_reg.start_y[31], pts_reg.start_y} - {pts_reg.end_y[31], pts_reg.end_y};
                dif_b = {pts_reg.ctrl2_x[31], pts_reg.ctrl2_x} - {pts_reg.ctrl1_x[31], pts_reg.ctrl1_x};
            end
        endcase
        mag_a = dif_a[COORD_W] ? COORD_W'(-dif_a) : dif_a[COORD_W-1:0];
        mag_b = dif_b[COORD_W] ? COORD_W'(-dif_b) : dif_b[COORD_W-1:0];
    end

    assign area1  = abs_cross(prod_reg[0], prod_reg[1], neg_reg[0], neg_reg[1]);
    assign area2  = abs_cross(prod_reg[2], prod_reg[3], neg_reg[2], neg_reg[3]);
    assign sq_bit = AREA_W'(1) << {sq_pos_reg, 1'b0};
    assign sq_try = sq_root_reg + sq_bit;

    assign n_raw   = sq_root_reg >> (COORD_FRAC_BITS + 2);
    assign few_seg = n_raw <= AREA_W'(1);
    assign cap     = (max_seg_reg < SEG_W'(MIN_SEG)) ? SEG_W'(MIN_SEG) : max_seg_reg;
    assign n_clamp = (n_raw > AREA_W'(cap)) ? cap :
                     (n_raw < AREA_W'(MIN_SEG)) ? SEG_W'(MIN_SEG) : n_raw[SEG_W-1:0];

    bzf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (val_reg[dv_idx_reg]),
        .divisor  (d_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_CROSS;
            ST_CROSS: if (k_reg == 2'd3) state_next = ST_AREA;
            ST_AREA:  state_next = ST_SQRT;
            ST_SQRT:  if (sq_pos_reg == '0) state_next = ST_CLAMP;
            ST_CLAMP: state_next = few_seg ? ST_LAST : ST_COEF;
            ST_COEF:  state_next = ST_MULS;
            ST_MULS:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_DIV;
            ST_DIV:
                if (div_done && dv_idx_reg == 3'(N_DIFF - 1)) state_next = ST_INIT;
            ST_INIT:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_EMIT;
            ST_EMIT:
                state_next = (i_reg == n_reg - SEG_W'(1)) ? ST_LAST : ST_UPD;
            ST_LAST:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy     = state_reg != ST_IDLE;
        accept   = start && (state_reg == ST_IDLE);
        emit_pt  = state_reg == ST_EMIT;
        emit_end = state_reg == ST_LAST;
        div_go   = (state_reg == ST_DIV) && !dv_pend_reg && !div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_seg_reg <= SEG_W'(MAX_SEG_RST);
            k_reg       <= '0;
            sq_pos_reg  <= '0;
            dv_idx_reg  <= '0;
            dv_pend_reg <= 1'b0;
            i_reg       <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= accept || emit_pt || emit_end;
            if (cfg_we)
                max_seg_reg <= cfg_data;
            if (accept)
                k_reg <= '0;
            else if (state_reg == ST_CROSS)
                k_reg <= k_reg + 2'd1;
            if (state_reg == ST_AREA)
                sq_pos_reg <= 5'(SQRT_STEPS - 1);
            else if (state_reg == ST_SQRT)
                sq_pos_reg <= sq_pos_reg - 5'd1;
            if (state_reg == ST_DIFF)
                dv_idx_reg <= '0;
            else if (div_done)
                dv_idx_reg <= dv_idx_reg + 3'd1;
            if (div_go)
                dv_pend_reg <= 1'b1;
            else if (div_done)
                dv_pend_reg <= 1'b0;
            if (state_reg == ST_INIT)
                i_reg <= SEG_W'(1);
            else if (emit_pt)
                i_reg <= i_reg + SEG_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pts_reg            <= points;
            result_reg.point_x <= points.start_x;
            result_reg.point_y <= points.start_y;
            result_reg.last    <= 1'b0;
        end
        if (emit_pt)
        begin
            result_reg.point_x <= sat_add(pts_reg.start_x, acc_reg[0].q);
            result_reg.point_y <= sat_add(pts_reg.start_y, acc_reg[1].q);
            result_reg.last    <= 1'b0;
        end
        if (emit_end)
        begin
            result_reg.point_x <= pts_reg.end_x;
            result_reg.point_y <= pts_reg.end_y;
            result_reg.last    <= 1'b1;
        end
        case (state_reg)
            ST_CROSS:
            begin
                prod_reg[k_reg] <= AREA_W'(mag_a) * AREA_W'(mag_b);
                neg_reg[k_reg]  <= dif_a[COORD_W] ^ dif_b[COORD_W];
            end
            ST_AREA:
            begin
                sq_rem_reg  <= (area2 > area1) ? area2 : area1;
                sq_root_reg <= '0;
            end
            ST_SQRT:
            begin
                if (sq_rem_reg >= sq_try)
                begin
                    sq_rem_reg  <= sq_rem_reg - sq_try;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_root_reg <= sq_root_reg >> 1;
                end
            end
            ST_CLAMP:
                n_reg <= n_clamp;
            ST_COEF:
            begin
                n2_reg <= (2*SEG_W)'(n_reg) * (2*SEG_W)'(n_reg);
                for (int l = 0; l < N_LANE; l++)
                begin
                    ca_reg[l] <= ext(p3[l]) - 3 * ext(p2[l]) + 3 * ext(p1[l]) - ext(p0[l]);
                    cb_reg[l] <= 3 * (ext(p2[l]) - 2 * ext(p1[l]) + ext(p0[l]));
                    cc_reg[l] <= 3 * (ext(p1[l]) - ext(p0[l]));
                end
            end
            ST_MULS:
            begin
                d_reg <= DEN_W'(n2_reg) * DEN_W'(n_reg);
                for (int l = 0; l < N_LANE; l++)
                begin
                    bn_reg[l] <= VAL_W'(cb_reg[l]) * $signed(VAL_W'(n_reg));
                    cn_reg[l] <= VAL_W'(cc_reg[l]) * $signed(VAL_W'(n2_reg));
                end
            end
            ST_DIFF:
            begin
                for (int l = 0; l < N_LANE; l++)
                begin
                    val_reg[3*l]   <= VAL_W'(ca_reg[l]) + bn_reg[l] + cn_reg[l];
                    val_reg[3*l+1] <= 6 * VAL_W'(ca_reg[l]) + 2 * bn_reg[l];
                    val_reg[3*l+2] <= 6 * VAL_W'(ca_reg[l]);
                end
            end
            ST_DIV:
                if (div_done)
                    dm_reg[dv_idx_reg] <= div_quot;
            ST_INIT:
            begin
                for (int l = 0; l < N_LANE; l++)
                begin
                    acc_reg[l].q <= '0;
                    acc_reg[l].r <= d_reg >> 1;
                end
            end
            ST_UPD:
            begin
                for (int l = 0; l < N_LANE; l++)
                begin
                    acc_reg[l]    <= madd(acc_reg[l], dm_reg[3*l], d_reg);
                    dm_reg[3*l]   <= madd(dm_reg[3*l], dm_reg[3*l+1], d_reg);
                    dm_reg[3*l+1] <= madd(dm_reg[3*l+1], dm_reg[3*l+2], d_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

>>> design/bzf_chk.sv
// ----------------------------------------------------------------------------
// bzf_chk
// Port-level checks for the cubic Bezier flattener, bound to the top level.
// ----------------------------------------------------------------------------
module bzf_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                valid,
    input bzf_pkg::bzf_out_t   result
);
    import bzf_pkg::*;

    // accepted word: busy next cycle and start point out
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && valid && !result.last)
        else $error("accepted word did not produce start point");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && result.last)
        else $error("run ended without last point");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last |-> !busy)
        else $error("last point while still busy");

    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !busy |-> result.last)
        else $error("non-final point while idle");

endmodule

bind cubic_bezier_flattener bzf_chk u_bzf_chk (.*);

>>> sim/bzf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bzf_checker
// Watches the input, config and result channels of the Bezier flattener,
// predicts the polyline of every accepted curve and compares each result word.
// ----------------------------------------------------------------------------
module bzf_checker
    import bzf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  bzf_in_t             points,
    input  logic                cfg_we,
    input  logic [SEG_W-1:0]    cfg_data,
    input  logic                valid,
    input  bzf_out_t            result,
    output int                  errors,
    output int                  pending
);

    logic [SEG_W-1:0] seg_limit;
    bzf_out_t         poly_q[$];

    assign pending = poly_q.size();

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] cross_mag(input longint p, q, r, s);
        logic [63:0] m1;
        logic [63:0] m2;
        logic [64:0] sum;
        m1 = mag64(p) * mag64(q);
        m2 = mag64(r) * mag64(s);
        if (((p < 0) != (q < 0)) != ((r < 0) != (s < 0)))
        begin
            sum = {1'b0, m1} + {1'b0, m2};
            return sum[64] ? '1 : sum[63:0];
        end
        return m1 >= m2 ? m1 - m2 : m2 - m1;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint near_div(input longint s, input longint d);
        longint num;
        num = s + d / 2;
        if (num >= 0)
            return num / d;
        return -((-num + d - 1) / d);
    endfunction

    task automatic flatten_curve(input bzf_in_t c);
        longint x0, y0, x1, y1, x2, y2, x3, y3;
        longint nn, den, ax, bx, cx, ay, by, cy;
        longint sx, dx1, dx2, dx3, sy, dy1, dy2, dy3;
        logic [63:0] ar;
        logic [63:0] br;
        logic [63:0] n;
        logic [63:0] cap;
        bzf_out_t w;
        x0 = c.start_x; y0 = c.start_y;
        x1 = c.ctrl1_x; y1 = c.ctrl1_y;
        x2 = c.ctrl2_x; y2 = c.ctrl2_y;
        x3 = c.end_x;   y3 = c.end_y;
        ar = cross_mag(x0 - x2, y3 - y1, y0 - y2, x3 - x1);
        br = cross_mag(x0 - x3, y2 - y1, y0 - y3, x2 - x1);
        if (br > ar)
            ar = br;
        n = root64(ar) >> (FRAC_BITS_DEF + 2);
        w = '{point_x: c.start_x, point_y: c.start_y, last: 1'b0};
        poly_q.push_back(w);
        if (n > 1)
        begin
            cap = (seg_limit < MIN_SEG) ? MIN_SEG : seg_limit;
            if (n > cap)
                n = cap;
            if (n < MIN_SEG)
                n = MIN_SEG;
            nn  = n;
            den = nn * nn * nn;
            ax = x3 - 3 * x2 + 3 * x1 - x0;
            bx = 3 * (x2 - 2 * x1 + x0);
            cx = 3 * (x1 - x0);
            ay = y3 - 3 * y2 + 3 * y1 - y0;
            by = 3 * (y2 - 2 * y1 + y0);
            cy = 3 * (y1 - y0);
            sx = 0; dx1 = ax + bx * nn + cx * nn * nn; dx2 = 6 * ax + 2 * bx * nn; dx3 = 6 * ax;
            sy = 0; dy1 = ay + by * nn + cy * nn * nn; dy2 = 6 * ay + 2 * by * nn; dy3 = 6 * ay;
            for (longint i = 1; i < nn; i++)
            begin
                sx += dx1; dx1 += dx2; dx2 += dx3;
                sy += dy1; dy1 += dy2; dy2 += dy3;
                w.point_x = clip32(x0 + near_div(sx, den));
                w.point_y = clip32(y0 + near_div(sy, den));
                poly_q.push_back(w);
            end
        end
        w = '{point_x: c.end_x, point_y: c.end_y, last: 1'b1};
        poly_q.push_back(w);
    endtask

    initial
        errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bzf_out_t exp_w;
        if (!rst_n)
            seg_limit <= SEG_W'(MAX_SEG_RST);
        else
        begin
            if (start && !busy)
                flatten_curve(points);
            if (valid)
            begin
                if (poly_q.size() == 0)
                    report($sformatf("unexpected word x=%h y=%h last=%b",
                                     result.point_x, result.point_y, result.last));
                else
                begin
                    exp_w = poly_q.pop_front();
                    if (result.point_x !== exp_w.point_x)
                        report($sformatf("point_x %h, expected %h",
                                         result.point_x, exp_w.point_x));
                    if (result.point_y !== exp_w.point_y)
                        report($sformatf("point_y %h, expected %h",
                                         result.point_y, exp_w.point_y));
                    if (result.last !== exp_w.last)
                        report($sformatf("last %b, expected %b",
                                         result.last, exp_w.last));
                end
            end
            if (cfg_we)
                seg_limit <= cfg_data;
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives curves and max_segments settings into the Bezier flattener in bursts,
// with a watchdog; the checker predicts and compares the polyline words.
// ----------------------------------------------------------------------------
module tb_top;
    import bzf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    bzf_in_t          points;
    logic             cfg_we;
    logic [SEG_W-1:0] cfg_data;
    logic             valid;
    bzf_out_t         result;
    int               errors;
    int               pending;
    int               idle_cycles;

    cubic_bezier_flattener u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .points   (points),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .valid    (valid),
        .result   (result)
    );

    bzf_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .points   (points),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .valid    (valid),
        .result   (result),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] near(input logic [31:0] base, input int span);
        return base + 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic bzf_in_t rand_curve();
        bzf_in_t c;
        logic [31:0] bx;
        logic [31:0] by;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        bx = $urandom();
        by = $urandom();
        if (kind >= 8)
            c = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
        else
        begin
            span = (kind < 2) ? (1 << 16) : (1 << $urandom_range(17, 25));
            c.start_x = bx;             c.start_y = by;
            c.ctrl1_x = near(bx, span); c.ctrl1_y = near(by, span);
            c.ctrl2_x = near(bx, span); c.ctrl2_y = near(by, span);
            c.end_x   = near(bx, span); c.end_y   = near(by, span);
        end
        return c;
    endfunction

    task automatic send_curve(input bzf_in_t c);
        start  <= 1'b1;
        points <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_burst(input int count);
        int left;
        int gap;
        left = count;
        while (left > 0)
        begin
            gap = $urandom_range(1, 8);
            for (int k = 0; k < gap && left > 0; k++, left--)
                send_curve(rand_curve());
            start <= 1'b0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [SEG_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        start    = 1'b0;
        points   = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        rst_n    = 1'b0;
        idle_cycles = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, extremes, mid-size, large, small
        send_curve('0);
        send_curve('1);
        send_curve({8{32'h7FFF_FFFF}});
        send_curve({8{32'h8000_0000}});
        send_curve({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_curve({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_curve({32'h0, 32'h0, 32'h0040_0000, 32'h0, 32'h0040_0000, 32'h0040_0000,
                    32'h0, 32'h0040_0000});
        send_curve({32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0010_0000,
                    32'h0, 32'h0010_0000});
        send_curve({32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555});
        send_curve({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
                    32'h0, 32'h0001_0000});
        drain();
        set_limit(SEG_W'(MIN_SEG));
        send_curve({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        drain();
        set_limit(SEG_W'(0));
        send_curve({32'h0, 32'h0, 32'h0040_0000, 32'h0, 32'h0040_0000, 32'h0040_0000,
                    32'h0, 32'h0040_0000});
        drain();

        set_limit(SEG_W'(MAX_SEG_RST));
        send_burst(25);
        drain();
        set_limit(SEG_W'(MIN_SEG));
        send_burst(20);
        drain();
        set_limit(SEG_W'(5));
        send_burst(15);
        drain();
        set_limit(SEG_W'($urandom_range(10, 62)));
        send_burst(25);
        drain();
        set_limit(SEG_W'(MAX_SEG_RST));
        send_burst(35);

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
